@@ hdl/ffa_pkg.sv @@
// Shared definitions for the first-fit heap allocator.
// Request and response beat types, operation and status codes, default sizes.
// No dependencies.
`default_nettype none

package ffa_pkg;

    // Default sizing of the allocator
    localparam int MAX_BLOCKS_DEFAULT     = 64;
    localparam int HEAP_ADDR_BITS_DEFAULT = 20;
    localparam int HEADER_BYTES_DEFAULT   = 16;

    // Fixed field widths of the request and response beats
    localparam int SIZE_BITS  = 21;
    localparam int DADDR_BITS = 20;
    localparam int OP_BITS    = 2;
    localparam int STAT_BITS  = 2;

    // Heap limit after reset: 1 MiB
    localparam logic [SIZE_BITS-1:0] HEAP_LIMIT_RESET = 21'h10_0000;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RESIZE = 2'd2;

    // Status codes
    localparam logic [STAT_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] STATUS_NO_MEM   = 2'd1;
    localparam logic [STAT_BITS-1:0] STATUS_BAD_ADDR = 2'd2;

    // Request beat
    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [SIZE_BITS-1:0]  request_size;
        logic [DADDR_BITS-1:0] data_address;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [DADDR_BITS-1:0] result_address;
        logic [STAT_BITS-1:0]  status;
        logic [SIZE_BITS-1:0]  copy_length;
    } t_rsp;

endpackage

`default_nettype wire

@@ hdl/ffa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the allocator block table. No dependencies.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: sequencer, block table walk, result register.
// Depends on ffa_pkg (types, codes) and ffa_ram (block table storage).
//
// The block keeps a table of heap blocks in address order in a RAM, one entry per
// block (header start, data size, free mark), plus the block count and the heap
// break. One request is handled at a time: o_stall is low only while idle. A request
// that needs a walk reads the table through the single RAM read port, one entry per
// cycle, stopping at the first free block that fits (allocate) or at the block whose
// data offset matches (free, resize); a resize that relocates walks twice. Requests
// that need no walk (null sizes, null frees, undefined operations) go straight to
// the result. The result sits in an output register, so the next request is taken
// while a result still waits on i_stall. The heap limit is written through
// i_cfg_wr_en and i_cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. No clearing pass after reset:
// table entries at or above the block count are never read.
`default_nettype none

module first_fit_heap_allocator
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS     = MAX_BLOCKS_DEFAULT,
    parameter int HEAP_ADDR_BITS = HEAP_ADDR_BITS_DEFAULT,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_req                 i_req,
    // response channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_rsp                      o_rsp,
    // heap limit register
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [SIZE_BITS-1:0] i_cfg_wr_data
);

    localparam int AW = HEAP_ADDR_BITS;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int WW = ((AW > SIZE_BITS) ? AW : SIZE_BITS) + 2;
    localparam int EW = AW + SIZE_BITS + 1;

    localparam logic [WW-1:0] HDR       = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] CAP       = WW'(1) << AW;
    localparam logic [WW-1:0] ADDR_MASK = {{(WW - AW){1'b0}}, {AW{1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SCAN     = 4'b0010,
        S_FREE_OLD = 4'b0100,
        S_RESULT   = 4'b1000
    } t_state;

    t_state                 r_state;
    t_req                   r_req;
    logic                   r_fit;
    logic                   r_reloc;
    logic                   r_pend;
    logic [CW-1:0]          r_rd_idx;
    logic [IW-1:0]          r_chk_idx;
    logic [IW-1:0]          r_old_idx;
    logic [AW-1:0]          r_old_start;
    logic [SIZE_BITS-1:0]   r_old_size;
    logic [CW-1:0]          r_count;
    logic [AW:0]            r_break;
    logic [SIZE_BITS-1:0]   r_limit;
    t_rsp                   r_rsp;
    t_rsp                   r_out;
    logic                   r_out_valid;

    // table RAM ports
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [EW-1:0]          ram_rdata;

    // fields of the entry read back
    logic [AW-1:0]          rd_start;
    logic [SIZE_BITS-1:0]   rd_size;
    logic                   rd_free;

    logic [WW-1:0]          e_off;
    logic [WW-1:0]          e_off_m;
    logic                   hit;
    logic                   more;
    logic [WW-1:0]          top;
    logic [WW-1:0]          lim;
    logic                   can_append;
    logic [WW-1:0]          brk_off_m;
    logic [WW-1:0]          old_end;
    logic                   old_is_top;
    logic                   accept;

    assign rd_start = ram_rdata[AW-1:0];
    assign rd_size  = ram_rdata[AW+SIZE_BITS-1:AW];
    assign rd_free  = ram_rdata[EW-1];

    // compare and address arithmetic shared by every step of the walk
    always_comb begin
        e_off      = WW'(rd_start) + HDR;
        e_off_m    = e_off & ADDR_MASK;
        if (r_fit) begin
            hit = r_pend && rd_free && (rd_size >= r_req.request_size);
        end else begin
            hit = r_pend && (e_off == WW'(r_req.data_address));
        end
        more       = r_rd_idx < r_count;
        top        = WW'(r_break) + HDR + WW'(r_req.request_size);
        lim        = (WW'(r_limit) < CAP) ? WW'(r_limit) : CAP;
        can_append = (r_count != CW'(MAX_BLOCKS)) && (top <= lim);
        brk_off_m  = (WW'(r_break) + HDR) & ADDR_MASK;
        old_end    = WW'(r_old_start) + HDR + WW'(r_old_size);
        old_is_top = (old_end == WW'(r_break)) &&
                     ((CW'(r_old_idx) + CW'(1)) == r_count);
    end

    // table write and read control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = {1'b0, rd_size, rd_start};
        ram_re    = 1'b0;
        case (r_state)
            S_SCAN: begin
                if (hit) begin
                    // claim the fitting block
                    ram_we = r_fit;
                end else if (more) begin
                    ram_re = 1'b1;
                end else if (r_fit && can_append) begin
                    // new block at the break
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IW-1:0];
                    ram_wdata = {1'b0, r_req.request_size, r_break[AW-1:0]};
                end
            end
            S_FREE_OLD: begin
                ram_we    = !old_is_top;
                ram_waddr = r_old_idx;
                ram_wdata = {1'b1, r_old_size, r_old_start};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign accept = i_valid && (r_state == S_IDLE);

    // heap limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= HEAP_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_break     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat taken; a result load in S_RESULT keeps it set
            if (r_out_valid && !i_stall && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req                <= i_req;
                        r_rd_idx             <= '0;
                        r_pend               <= 1'b0;
                        r_reloc              <= 1'b0;
                        r_rsp.result_address <= '0;
                        r_rsp.copy_length    <= '0;
                        case (i_req.operation)
                            OP_ALLOC: begin
                                if (i_req.request_size == '0) begin
                                    r_rsp.status <= STATUS_NO_MEM;
                                    r_state      <= S_RESULT;
                                end else begin
                                    r_rsp.status <= STATUS_OK;
                                    r_fit        <= 1'b1;
                                    r_state      <= S_SCAN;
                                end
                            end
                            OP_FREE: begin
                                r_rsp.status <= STATUS_OK;
                                if (i_req.data_address == '0) begin
                                    r_state <= S_RESULT;
                                end else begin
                                    r_fit   <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_RESIZE: begin
                                if (i_req.request_size == '0) begin
                                    r_rsp.status <= STATUS_NO_MEM;
                                    r_state      <= S_RESULT;
                                end else if (i_req.data_address == '0) begin
                                    r_rsp.status <= STATUS_OK;
                                    r_fit        <= 1'b1;
                                    r_state      <= S_SCAN;
                                end else begin
                                    r_rsp.status <= STATUS_OK;
                                    r_fit        <= 1'b0;
                                    r_state      <= S_SCAN;
                                end
                            end
                            default: begin
                                r_rsp.status <= STATUS_OK;
                                r_state      <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (hit && r_fit) begin
                        // first fit found, no split
                        r_pend                <= 1'b0;
                        r_rsp.result_address  <= e_off_m[DADDR_BITS-1:0];
                        r_rsp.status          <= STATUS_OK;
                        r_rsp.copy_length     <= r_reloc ? r_old_size : '0;
                        r_state               <= r_reloc ? S_FREE_OLD : S_RESULT;
                    end else if (hit) begin
                        // address match
                        r_pend      <= 1'b0;
                        r_old_idx   <= r_chk_idx;
                        r_old_start <= rd_start;
                        r_old_size  <= rd_size;
                        if (r_req.operation == OP_FREE) begin
                            r_state <= S_FREE_OLD;
                        end else if (rd_size >= r_req.request_size) begin
                            r_rsp.result_address <= r_req.data_address;
                            r_state              <= S_RESULT;
                        end else begin
                            // too small: walk again for a new block
                            r_reloc  <= 1'b1;
                            r_fit    <= 1'b1;
                            r_rd_idx <= '0;
                        end
                    end else if (more) begin
                        r_pend    <= 1'b1;
                        r_chk_idx <= r_rd_idx[IW-1:0];
                        r_rd_idx  <= r_rd_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (r_fit && can_append) begin
                            // grow the heap
                            r_count              <= r_count + CW'(1);
                            r_break              <= top[AW:0];
                            r_rsp.result_address <= brk_off_m[DADDR_BITS-1:0];
                            r_rsp.status         <= STATUS_OK;
                            r_rsp.copy_length    <= r_reloc ? r_old_size : '0;
                            r_state              <= r_reloc ? S_FREE_OLD : S_RESULT;
                        end else if (r_fit) begin
                            r_rsp.status <= STATUS_NO_MEM;
                            r_state      <= S_RESULT;
                        end else begin
                            r_rsp.status <= STATUS_BAD_ADDR;
                            r_state      <= S_RESULT;
                        end
                    end
                end

                S_FREE_OLD: begin
                    // top block drops off the heap, others are marked free
                    if (old_is_top) begin
                        r_break <= (AW + 1)'(r_old_start);
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_RESULT;
                end

                S_RESULT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

`default_nettype wire
